// ===== src/dohrp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the DNS-over-HTTP response parser.
// Holds parse phases, status codes, character codes and the match patterns.
package dohrp_pkg;

  typedef enum logic [3:0] {
    PH_VERSION      = 4'd0,
    PH_STATUS_CODE  = 4'd1,
    PH_STATUS_MSG   = 4'd2,
    PH_WAIT_CRLF    = 4'd3,
    PH_HDR_CONTENT  = 4'd4,
    PH_HDR_TYPE     = 4'd5,
    PH_HDR_LENGTH   = 4'd6,
    PH_TYPE_VALUE   = 4'd7,
    PH_LENGTH_VALUE = 4'd8,
    PH_INSTANT_LB   = 4'd9,
    PH_END_OF_HDR   = 4'd10,
    PH_BODY         = 4'd11,
    PH_FINISHED     = 4'd12,
    PH_ERROR        = 4'd13
  } phase_e;

  typedef enum logic [1:0] {
    ST_HEADER = 2'd0,
    ST_BODY   = 2'd1,
    ST_DONE   = 2'd2,
    ST_ERROR  = 2'd3
  } status_e;

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  localparam logic [4:0] VERSION_LEN = 5'd8;
  localparam logic [4:0] CODE_LEN    = 5'd3;
  localparam logic [4:0] MSG_LEN     = 5'd2;
  localparam logic [4:0] CONTENT_LEN = 5'd8;
  localparam logic [4:0] TYPE_LEN    = 5'd5;
  localparam logic [4:0] LENGTH_LEN  = 5'd7;
  localparam logic [4:0] VALUE_LEN   = 5'd23;
  localparam logic [4:0] COUNT_MAX   = 5'd31;

  // "HTTP/1.0"
  function automatic logic [7:0] pat_version(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "H";
      5'd1:    c = "T";
      5'd2:    c = "T";
      5'd3:    c = "P";
      5'd4:    c = "/";
      5'd5:    c = "1";
      5'd6:    c = ".";
      5'd7:    c = "0";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "200"
  function automatic logic [7:0] pat_code(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "2";
      5'd1:    c = "0";
      5'd2:    c = "0";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "OK"
  function automatic logic [7:0] pat_msg(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "O";
      5'd1:    c = "K";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "content-"
  function automatic logic [7:0] pat_content(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "c";
      5'd1:    c = "o";
      5'd2:    c = "n";
      5'd3:    c = "t";
      5'd4:    c = "e";
      5'd5:    c = "n";
      5'd6:    c = "t";
      5'd7:    c = "-";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "type:"
  function automatic logic [7:0] pat_type(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "t";
      5'd1:    c = "y";
      5'd2:    c = "p";
      5'd3:    c = "e";
      5'd4:    c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "length:"
  function automatic logic [7:0] pat_length(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "l";
      5'd1:    c = "e";
      5'd2:    c = "n";
      5'd3:    c = "g";
      5'd4:    c = "t";
      5'd5:    c = "h";
      5'd6:    c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "application/dns-message"
  function automatic logic [7:0] pat_value(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "a";
      5'd1:    c = "p";
      5'd2:    c = "p";
      5'd3:    c = "l";
      5'd4:    c = "i";
      5'd5:    c = "c";
      5'd6:    c = "a";
      5'd7:    c = "t";
      5'd8:    c = "i";
      5'd9:    c = "o";
      5'd10:   c = "n";
      5'd11:   c = "/";
      5'd12:   c = "d";
      5'd13:   c = "n";
      5'd14:   c = "s";
      5'd15:   c = "-";
      5'd16:   c = "m";
      5'd17:   c = "e";
      5'd18:   c = "s";
      5'd19:   c = "s";
      5'd20:   c = "a";
      5'd21:   c = "g";
      5'd22:   c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] low_case(input logic [7:0] c);
    return (c inside {["A":"Z"]}) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

endpackage

// ===== src/dns_over_http_response_parser.sv =====
`timescale 1ns / 1ps
// Top level of the DNS-over-HTTP response parser: byte-wide header scanner
// and body pass-through. Depends on dohrp_pkg.

// Streaming parser for an HTTP/1.0 response carrying a DNS message. Feed one
// response byte per transaction on the input channel; every accepted byte
// yields exactly one result transaction with a status (header, body byte,
// finished, error), the body byte itself, a last-body-byte mark, the content
// length parsed so far and the dns-message content-type flag. Set
// new_response_i with the first byte of each response to clear all parser
// state before that byte is taken. The block sustains one byte per clock
// while the result is not stalled: a byte is held in the input register,
// then the phase machine and the length accumulator (one shift-add and
// compare) update state and load the result register, which drives the
// output channel. The result register parts the two channels; a stalled
// result holds back only the input register, and the input stalls only
// while both registers are full and the result is stalled.
// Content lengths above 2^LENGTH_BITS - 1 report error; length_value_o
// carries the low 16 bits of the accumulated length.
module dns_over_http_response_parser #(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       new_response_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] parse_status_o,
  output logic [7:0] body_byte_o,
  output logic       body_last_o,
  output logic [15:0] length_value_o,
  output logic       dns_type_seen_o
);
  import dohrp_pkg::*;

  localparam int ExtBits = LENGTH_BITS + 4;

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_new_q;

  // Parser state.
  phase_e                 phase_q, phase_d;
  logic [4:0]             match_q, match_d;
  logic                   nonempty_q, nonempty_d;
  logic [LENGTH_BITS-1:0] accum_q, accum_d;
  logic                   known_q, known_d;
  logic                   typed_q, typed_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;

  // Result register.
  logic        out_vld_q;
  status_e     status_q, status_d;
  logic [7:0]  body_q, body_d;
  logic        last_q, last_d;
  logic [15:0] len_q, len_d;
  logic        seen_q, seen_d;

  logic process;
  logic emit;

  // Fire the parser whenever a byte waits and the result slot is free or draining.
  assign process    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !process;

  // Current state as seen by this byte: new_response clears it first.
  phase_e                 ph_c;
  logic [4:0]             mc_c;
  logic                   ne_c;
  logic [LENGTH_BITS-1:0] acc_c;
  logic                   kn_c;
  logic                   ty_c;
  logic [LENGTH_BITS-1:0] cnt_c;

  always_comb begin
    if (in_new_q) begin
      ph_c  = PH_VERSION;
      mc_c  = 5'd0;
      ne_c  = 1'b0;
      acc_c = '0;
      kn_c  = 1'b0;
      ty_c  = 1'b0;
      cnt_c = '0;
    end else begin
      ph_c  = phase_q;
      mc_c  = match_q;
      ne_c  = nonempty_q;
      acc_c = accum_q;
      kn_c  = known_q;
      ty_c  = typed_q;
      cnt_c = count_q;
    end
  end

  // Length accumulation: accum * 10 + digit, widened to spot overflow.
  logic [7:0]             b;
  logic [7:0]             lc;
  logic [ExtBits-1:0]     acc_ext;
  logic [ExtBits-1:0]     next_len;
  logic                   len_ovf;
  logic [LENGTH_BITS-1:0] cnt_inc;

  assign b        = in_byte_q;
  assign lc       = low_case(in_byte_q);
  assign acc_ext  = {4'd0, acc_c};
  assign next_len = (acc_ext << 3) + (acc_ext << 1) + {{LENGTH_BITS{1'b0}}, b[3:0]};
  assign len_ovf  = |next_len[ExtBits-1:LENGTH_BITS];
  assign cnt_inc  = cnt_c + {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  // Next state.
  always_comb begin
    phase_d    = ph_c;
    match_d    = mc_c;
    nonempty_d = ne_c;
    accum_d    = acc_c;
    known_d    = kn_c;
    typed_d    = ty_c;
    count_d    = cnt_c;
    case (ph_c)
      PH_VERSION: begin
        if (mc_c < VERSION_LEN && b == pat_version(mc_c)) begin
          match_d = mc_c + 5'd1;
        end else if (mc_c == VERSION_LEN && b == CH_SP) begin
          phase_d = PH_STATUS_CODE;
          match_d = 5'd0;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_STATUS_CODE: begin
        if (mc_c < CODE_LEN && b == pat_code(mc_c)) begin
          match_d = mc_c + 5'd1;
        end else if (mc_c == CODE_LEN && b == CH_SP) begin
          phase_d = PH_STATUS_MSG;
          match_d = 5'd0;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_STATUS_MSG: begin
        if (mc_c < MSG_LEN && b == pat_msg(mc_c)) begin
          if (mc_c + 5'd1 == MSG_LEN) begin
            phase_d = PH_WAIT_CRLF;
            match_d = 5'd0;
          end else begin
            match_d = mc_c + 5'd1;
          end
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_WAIT_CRLF: begin
        if (b == CH_CR && mc_c == 5'd0) begin
          match_d = 5'd1;
        end else if (b == CH_LF && mc_c <= 5'd1) begin
          nonempty_d = 1'b0;
          match_d    = 5'd0;
          phase_d    = PH_HDR_CONTENT;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_HDR_CONTENT: begin
        if (!ne_c && (b == CH_CR || b == CH_LF)) begin
          phase_d = PH_ERROR;
        end else if (b == CH_LF) begin
          nonempty_d = 1'b0;
        end else begin
          nonempty_d = 1'b1;
          if (mc_c == CONTENT_LEN) begin
            // Prefix matched: pick the header by its next letter.
            if (lc == pat_length(5'd0) && !kn_c) begin
              phase_d = PH_HDR_LENGTH;
              match_d = 5'd1;
            end else if (lc == pat_type(5'd0) && !ty_c) begin
              phase_d = PH_HDR_TYPE;
              match_d = 5'd1;
            end else begin
              match_d = 5'd0;
            end
          end else if (mc_c < CONTENT_LEN && lc == pat_content(mc_c)) begin
            match_d = mc_c + 5'd1;
          end else begin
            match_d = 5'd0;
          end
        end
      end
      PH_HDR_TYPE: begin
        if (b == CH_LF && ne_c) begin
          phase_d = PH_ERROR;
        end else begin
          nonempty_d = 1'b1;
          if (mc_c == TYPE_LEN) begin
            if (b == CH_SP) begin
              match_d = 5'd0;
              phase_d = PH_TYPE_VALUE;
            end else if (lc != pat_value(5'd0)) begin
              phase_d = PH_ERROR;
            end else begin
              match_d = 5'd1;
              phase_d = PH_TYPE_VALUE;
            end
          end else if (mc_c < TYPE_LEN && lc == pat_type(mc_c)) begin
            match_d = mc_c + 5'd1;
          end else begin
            phase_d = PH_HDR_CONTENT;
            match_d = 5'd0;
          end
        end
      end
      PH_HDR_LENGTH: begin
        if (b == CH_LF && ne_c) begin
          phase_d = PH_ERROR;
        end else begin
          nonempty_d = 1'b1;
          if (mc_c == LENGTH_LEN) begin
            if (b == CH_SP) begin
              accum_d = '0;
              known_d = 1'b1;
              match_d = 5'd0;
              phase_d = PH_LENGTH_VALUE;
            end else if (!is_digit(b)) begin
              phase_d = PH_ERROR;
            end else begin
              accum_d = {{(LENGTH_BITS-4){1'b0}}, b[3:0]};
              known_d = 1'b1;
              match_d = 5'd1;
              phase_d = PH_LENGTH_VALUE;
            end
          end else if (mc_c < LENGTH_LEN && lc == pat_length(mc_c)) begin
            match_d = mc_c + 5'd1;
          end else begin
            phase_d = PH_HDR_CONTENT;
            match_d = 5'd0;
          end
        end
      end
      PH_TYPE_VALUE: begin
        if (mc_c < VALUE_LEN && lc == pat_value(mc_c)) begin
          if (mc_c + 5'd1 == VALUE_LEN) begin
            typed_d = 1'b1;
            match_d = 5'd0;
            phase_d = kn_c ? PH_END_OF_HDR : PH_WAIT_CRLF;
          end else begin
            match_d = mc_c + 5'd1;
          end
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_LENGTH_VALUE: begin
        if (is_digit(b)) begin
          if (len_ovf) begin
            phase_d = PH_ERROR;
          end else begin
            accum_d = next_len[LENGTH_BITS-1:0];
            if (mc_c < COUNT_MAX) begin
              match_d = mc_c + 5'd1;
            end
          end
        end else if (b == CH_CR) begin
          // Hold: carriage return inside the value is skipped.
        end else if (b == CH_LF) begin
          match_d    = 5'd0;
          nonempty_d = 1'b0;
          phase_d    = ty_c ? PH_INSTANT_LB : PH_HDR_CONTENT;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_INSTANT_LB: begin
        if (b == CH_LF && mc_c <= 5'd1) begin
          match_d = 5'd0;
          count_d = '0;
          phase_d = (acc_c == '0) ? PH_FINISHED : PH_BODY;
        end else if (b == CH_CR && mc_c == 5'd0) begin
          match_d = 5'd1;
        end else begin
          match_d = 5'd0;
          phase_d = PH_END_OF_HDR;
        end
      end
      PH_END_OF_HDR: begin
        if (b == CH_LF) begin
          phase_d = PH_INSTANT_LB;
        end
      end
      PH_BODY: begin
        count_d = cnt_inc;
        if (cnt_inc >= acc_c) begin
          phase_d = PH_FINISHED;
        end
      end
      PH_FINISHED: begin
      end
      PH_ERROR: begin
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase
  end

  // Result fields.
  assign emit = (ph_c == PH_BODY);

  always_comb begin
    if (phase_d == PH_ERROR) begin
      status_d = ST_ERROR;
    end else if (emit) begin
      status_d = ST_BODY;
    end else if (phase_d == PH_FINISHED) begin
      status_d = ST_DONE;
    end else begin
      status_d = ST_HEADER;
    end
    body_d = emit ? b : 8'd0;
    last_d = emit && (phase_d == PH_FINISHED);
    len_d  = 16'(accum_d);
    seen_d = typed_d;
  end

  // Input register: advance whenever the slot is not held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
      in_new_q  <= new_response_i;
    end
  end

  // Parser state: update once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_VERSION;
      match_q    <= 5'd0;
      nonempty_q <= 1'b0;
      accum_q    <= '0;
      known_q    <= 1'b0;
      typed_q    <= 1'b0;
      count_q    <= '0;
    end else if (process) begin
      phase_q    <= phase_d;
      match_q    <= match_d;
      nonempty_q <= nonempty_d;
      accum_q    <= accum_d;
      known_q    <= known_d;
      typed_q    <= typed_d;
      count_q    <= count_d;
    end
  end

  // Result register: load on process, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (process) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      status_q <= status_d;
      body_q   <= body_d;
      last_q   <= last_d;
      len_q    <= len_d;
      seen_q   <= seen_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign parse_status_o  = status_q;
  assign body_byte_o     = body_q;
  assign body_last_o     = last_q;
  assign length_value_o  = len_q;
  assign dns_type_seen_o = seen_q;

`ifndef SYNTH
  // A last-byte mark only rides on an emitted body byte.
  a_last_is_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && last_q |-> status_q == ST_BODY)
    else $error("body_last without a body byte");

  // Non-body results carry a zero byte.
  a_body_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && status_q != ST_BODY |-> body_q == 8'd0)
    else $error("body byte set outside the body");

  // While in the body, the byte count stays below the content length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> count_q < accum_q)
    else $error("body count reached length without finishing");

  // Errors are sticky until a new response starts.
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && phase_q == PH_ERROR && !in_new_q |=> phase_q == PH_ERROR)
    else $error("error phase left without new response");

  // A stalled result holds the byte in the full input register.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && out_stall_i |=> in_vld_q && $stable(in_byte_q))
    else $error("input byte lost under output stall");
`endif

endmodule
